[design/bresenham_line_pixel_stepper_defines.svh]
// Assertion macros shared by the line stepper modules.
// Needs nothing else; each macro checks on the rising clock edge with reset as disable.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH

// Same-cycle implication.
`define BLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bls assertion failed");

// Next-cycle implication.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bls assertion failed");

`endif

[design/bls_pkg.sv]
// Shared types and constants of the line stepper.
// Used by the interfaces, the register block, the stepper and the pixel output stage.
package bls_pkg;

	localparam int REG_BITS   = 13;
	localparam int ADDR_BITS  = 24;
	localparam int COLOR_BITS = 32;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	// Item action codes.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Register indexes, taken from address bit 2.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [REG_BITS-1:0] width;
		logic [REG_BITS-1:0] height;
	} screen_t;

	typedef struct packed {
		logic pixel_valid;
		logic line_done;
	} pix_ctl_t;

endpackage

[design/bls_ifs.sv]
// Valid/ready channel interfaces for line items and emitted pixels.
// Depends on bls_pkg for the fixed field widths.
interface bls_item_if import bls_pkg::*; #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [COLOR_BITS-1:0]        line_color;

	modport source (output valid, action, start_x, start_y, end_x, end_y, line_color,
		input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, line_color,
		output ready);
endinterface

interface bls_pixel_if import bls_pkg::*; #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic                         pixel_valid;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         on_screen;
	logic [ADDR_BITS-1:0]         pixel_address;
	logic [COLOR_BITS-1:0]        pixel_color;
	logic                         line_done;

	modport source (output valid, pixel_valid, pixel_x, pixel_y, on_screen, pixel_address,
		pixel_color, line_done, input ready);
	modport sink (input valid, pixel_valid, pixel_x, pixel_y, on_screen, pixel_address,
		pixel_color, line_done, output ready);
endinterface

[design/bresenham_line_pixel_stepper.sv]
// Bresenham line pixel stepper.
// Input channel "item": action start loads both endpoints and a color and yields the
// first pixel; action step yields the next pixel of the running line. A step with no
// line running yields one result with every field zero and pixel_valid low.
// Output channel "pixel": exactly one result per item, in order, with coordinates,
// on-screen flag, linear address y*width+x (zero off screen), color and the mark of
// the end point, after which the line is finished.
// Registers on the APB port: screen width at byte 0, screen height at byte 4.
// An accepted item is registered in stage 1, then in the stage 2 output register,
// which offers it on "pixel". Throughput: one item per clock unless the receiver
// stalls; error update and end point compare sit in stage 1, address multiply in stage 2.
// Reset clears the line state (no line running), empties both stages and restores
// the screen size to 640 by 480.
// When the receiver stalls, the output register holds its result and stage 1 still
// takes one more item; ready falls once both stages are full and rises again as soon
// as the receiver takes a result.
// Depends on bls_pkg, the channel interfaces and the three submodules.
module bresenham_line_pixel_stepper import bls_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	bls_item_if.sink                 item,
	bls_pixel_if.source              pixel,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);
	screen_t                      screen;
	logic                         valid_s1, take_s1;
	pix_ctl_t                     ctl_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic [COLOR_BITS-1:0]        color_s1;

	bls_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.screen  (screen)
	);

	bls_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.color_s1 (color_s1)
	);

	bls_pixel_out #(.COORD_BITS(COORD_BITS)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.screen   (screen),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.color_s1 (color_s1),
		.take_s1  (take_s1),
		.pixel    (pixel)
	);
endmodule

[design/bls_cfg_regs.sv]
// APB register block holding the screen width and height.
// Depends on bls_pkg for the register layout and reset values.
module bls_cfg_regs import bls_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output screen_t                  screen
);
	logic    wr_en;
	screen_t screen_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q.width  <= WIDTH_RESET;
			screen_q.height <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  screen_q.width  <= pwdata[REG_BITS-1:0];
				REG_HEIGHT: screen_q.height <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = APB_DATA_BITS'(screen_q.width);
			REG_HEIGHT: prdata = APB_DATA_BITS'(screen_q.height);
			default:    prdata = '0;
		endcase
	end

	assign screen = screen_q;
endmodule

[design/bls_stepper.sv]
// Line state: setup on start, one Bresenham step per step item, registered into stage 1.
// Depends on bls_pkg, bls_item_if and the assertion macro header.
`include "bresenham_line_pixel_stepper_defines.svh"
module bls_stepper import bls_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bls_item_if.sink                     item,
	input  logic                         take_s1,
	output logic                         valid_s1,
	output pix_ctl_t                     ctl_s1,
	output logic signed [COORD_BITS-1:0] x_s1,
	output logic signed [COORD_BITS-1:0] y_s1,
	output logic [COLOR_BITS-1:0]        color_s1
);
	localparam int DW  = COORD_BITS + 1;
	localparam int NW  = COORD_BITS + 2;
	localparam int EW  = COORD_BITS + 3;
	localparam int E2W = COORD_BITS + 4;

	logic                         busy_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic signed [DW-1:0]         adx_q;
	logic signed [NW-1:0]         ndy_q;
	logic                         xneg_q, yneg_q;
	logic signed [EW-1:0]         err_q;
	logic [COLOR_BITS-1:0]        color_q;

	logic                         accept, is_start, emit, hit;
	logic signed [DW-1:0]         dx_st, dy_st, adx_st, ady_st;
	logic signed [NW-1:0]         ndy_st;
	logic signed [EW-1:0]         err_st, err_nx;
	logic                         xneg_st, yneg_st;
	logic signed [E2W-1:0]        e2;
	logic                         mx, my;
	logic signed [COORD_BITS-1:0] x_nx, y_nx, px, py, gx, gy;

	assign accept   = item.valid && item.ready;
	assign item.ready = !valid_s1 || take_s1;
	assign is_start = (item.action == ACT_START);

	// Setup of a new line from the endpoints.
	assign dx_st   = DW'(item.end_x) - DW'(item.start_x);
	assign dy_st   = DW'(item.end_y) - DW'(item.start_y);
	assign adx_st  = dx_st[DW-1] ? -dx_st : dx_st;
	assign ady_st  = dy_st[DW-1] ? -dy_st : dy_st;
	assign ndy_st  = -NW'(ady_st);
	assign err_st  = EW'(adx_st) + EW'(ndy_st);
	assign xneg_st = !(item.start_x < item.end_x);
	assign yneg_st = !(item.start_y < item.end_y);

	// One step of the running line.
	assign e2     = E2W'(err_q) <<< 1;
	assign mx     = e2 >= E2W'(ndy_q);
	assign my     = e2 <= E2W'(adx_q);
	assign err_nx = err_q + (mx ? EW'(ndy_q) : EW'(0)) + (my ? EW'(adx_q) : EW'(0));
	assign x_nx   = cur_x_q + (mx ? (xneg_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
		: COORD_BITS'(0));
	assign y_nx   = cur_y_q + (my ? (yneg_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
		: COORD_BITS'(0));

	assign px   = is_start ? item.start_x : x_nx;
	assign py   = is_start ? item.start_y : y_nx;
	assign gx   = is_start ? item.end_x : goal_x_q;
	assign gy   = is_start ? item.end_y : goal_y_q;
	assign hit  = (px == gx) && (py == gy);
	assign emit = is_start || busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && emit) begin
			busy_q <= !hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_start) begin
			cur_x_q  <= item.start_x;
			cur_y_q  <= item.start_y;
			goal_x_q <= item.end_x;
			goal_y_q <= item.end_y;
			adx_q    <= adx_st;
			ndy_q    <= ndy_st;
			xneg_q   <= xneg_st;
			yneg_q   <= yneg_st;
			err_q    <= err_st;
			color_q  <= item.line_color;
		end else if (accept && busy_q) begin
			cur_x_q <= x_nx;
			cur_y_q <= y_nx;
			err_q   <= err_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// A step while idle leaves an all-zero result.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.pixel_valid <= emit;
			ctl_s1.line_done   <= emit && hit;
			x_s1               <= emit ? px : '0;
			y_s1               <= emit ? py : '0;
			color_s1           <= emit ? (is_start ? item.line_color : color_q) : '0;
		end
	end

	`BLS_ASSERT_NEXT(a_idle_step_invalid, clk, arst_n,
		accept && (item.action == ACT_STEP) && !busy_q, valid_s1 && !ctl_s1.pixel_valid)
	`BLS_ASSERT_NEXT(a_end_point_goes_idle, clk, arst_n, accept && emit && hit, !busy_q)
	`BLS_ASSERT_NEXT(a_step_moves, clk, arst_n, accept && (item.action == ACT_STEP) && busy_q,
		(cur_x_q != $past(cur_x_q)) || (cur_y_q != $past(cur_y_q)))
endmodule

[design/bls_pixel_out.sv]
// Clipping test, linear address and the output register of the pixel channel.
// Depends on bls_pkg, bls_pixel_if and the assertion macro header.
`include "bresenham_line_pixel_stepper_defines.svh"
module bls_pixel_out import bls_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  screen_t                      screen,
	input  logic                         valid_s1,
	input  pix_ctl_t                     ctl_s1,
	input  logic signed [COORD_BITS-1:0] x_s1,
	input  logic signed [COORD_BITS-1:0] y_s1,
	input  logic [COLOR_BITS-1:0]        color_s1,
	output logic                         take_s1,
	bls_pixel_if.source                  pixel
);
	localparam int CMPW = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	localparam int PW   = COORD_BITS + REG_BITS;

	logic                         valid_s2;
	pix_ctl_t                     ctl_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;
	logic                         vis_s2;
	logic [ADDR_BITS-1:0]         addr_s2;
	logic [COLOR_BITS-1:0]        color_s2;

	logic            vis;
	logic [PW-1:0]   prod, sum;

	// Negative coordinates have the sign bit set and are never visible.
	assign vis = ctl_s1.pixel_valid && !x_s1[COORD_BITS-1] && !y_s1[COORD_BITS-1]
		&& (CMPW'($unsigned(x_s1)) < CMPW'(screen.width))
		&& (CMPW'($unsigned(y_s1)) < CMPW'(screen.height));
	assign prod = PW'($unsigned(y_s1)) * PW'(screen.width);
	assign sum  = prod + PW'($unsigned(x_s1));

	assign take_s1 = !valid_s2 || pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			ctl_s2   <= ctl_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			vis_s2   <= vis;
			addr_s2  <= vis ? ADDR_BITS'(sum) : '0;
			color_s2 <= color_s1;
		end
	end

	assign pixel.valid         = valid_s2;
	assign pixel.pixel_valid   = ctl_s2.pixel_valid;
	assign pixel.pixel_x       = x_s2;
	assign pixel.pixel_y       = y_s2;
	assign pixel.on_screen     = vis_s2;
	assign pixel.pixel_address = addr_s2;
	assign pixel.pixel_color   = color_s2;
	assign pixel.line_done     = ctl_s2.line_done;

	`BLS_ASSERT_NOW(a_offscreen_addr_zero, clk, arst_n, valid_s2 && !vis_s2, addr_s2 == '0)
	`BLS_ASSERT_NOW(a_invalid_not_drawn, clk, arst_n, valid_s2 && !ctl_s2.pixel_valid,
		!vis_s2 && !ctl_s2.line_done)
	`BLS_ASSERT_NEXT(a_stage_moves_on, clk, arst_n, take_s1 && valid_s1,
		valid_s2 && (ctl_s2 == $past(ctl_s1)))
endmodule
